### src/iidl_pkg.sv
// Package for the indexed insert/delete list: widths, depth, request codes,
// status codes and the command struct broadcast to the storage cells.
// No dependencies.
package iidl_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int IDX_W  = 5;
    localparam int CNT_W  = 5;
    localparam int SEL_W  = $clog2(DEPTH);

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2,
        OP_GET    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BOUNDS = 2'd1,
        ST_FULL   = 2'd2
    } status_t;

    typedef struct packed {
        logic              write_en;
        logic              up;
        logic              down;
        logic [CNT_W-1:0]  idx;
        logic [CNT_W-1:0]  len;
        logic [DATA_W-1:0] value;
    } cell_cmd_t;

endpackage

### src/iidl_cell.sv
// One storage cell of the list: holds a word, loads the new value or takes
// the word of its left or right neighbour as the broadcast command says.
// Depends on iidl_pkg.
module iidl_cell
    import iidl_pkg::*;
(
    input  logic              aclk,
    input  logic [CNT_W-1:0]  cell_pos,
    input  cell_cmd_t         cmd,
    input  logic [DATA_W-1:0] left_word,
    input  logic [DATA_W-1:0] right_word,
    output logic [DATA_W-1:0] word
);

    logic [DATA_W-1:0] word_reg;
    logic [DATA_W-1:0] word_next;
    logic [CNT_W:0]    pos_plus_one;

    assign pos_plus_one = {1'b0, cell_pos} + (CNT_W+1)'(1);

    always_comb begin
        word_next = word_reg;
        if (cmd.write_en && cell_pos == cmd.idx) begin
            word_next = cmd.value;
        end else if (cmd.up && cell_pos > cmd.idx && cell_pos <= cmd.len) begin
            word_next = left_word;
        end else if (cmd.down && cell_pos >= cmd.idx && pos_plus_one < {1'b0, cmd.len}) begin
            word_next = right_word;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

### src/iidl_ctrl.sv
// Request decode, bounds and full checks, length register and result
// register for the list; drives the command broadcast to the cells.
// Depends on iidl_pkg.
module iidl_ctrl
    import iidl_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_op,
    input  logic [IDX_W-1:0]  s_index,
    input  logic [DATA_W-1:0] s_value,
    input  logic [DATA_W-1:0] rd_word,
    output cell_cmd_t         cmd,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [DATA_W-1:0] m_read_value,
    output logic [1:0]        m_status,
    output logic [CNT_W-1:0]  m_count
);

    logic              accept;
    logic              full;
    op_t               op;
    status_t           st;
    logic [DATA_W-1:0] rd;
    logic [CNT_W-1:0]  length_reg, length_next;
    logic              m_valid_reg, m_valid_next;
    logic [DATA_W-1:0] rd_reg;
    status_t           st_reg;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign full    = (length_reg == CNT_W'(DEPTH));
    assign op      = op_t'(s_op);

    always_comb begin
        st          = ST_OK;
        rd          = '0;
        length_next = length_reg;
        cmd         = '0;
        cmd.len     = length_reg;
        cmd.value   = s_value;
        cmd.idx     = s_index;
        unique case (op)
            OP_APPEND: begin
                if (full) begin
                    st = ST_FULL;
                end else begin
                    cmd.write_en = accept;
                    cmd.idx      = length_reg;
                    length_next  = length_reg + CNT_W'(1);
                end
            end
            OP_INSERT: begin
                if (s_index > length_reg) begin
                    st = ST_BOUNDS;
                end else if (full) begin
                    st = ST_FULL;
                end else begin
                    cmd.write_en = accept;
                    cmd.up       = accept;
                    length_next  = length_reg + CNT_W'(1);
                end
            end
            OP_DELETE: begin
                if (s_index >= length_reg) begin
                    st = ST_BOUNDS;
                end else begin
                    cmd.down    = accept;
                    length_next = length_reg - CNT_W'(1);
                end
            end
            OP_GET: begin
                if (s_index >= length_reg) begin
                    st = ST_BOUNDS;
                    rd = '1;
                end else begin
                    rd = rd_word;
                end
            end
            default: begin
                st = ST_OK;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            length_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (accept) begin
                length_reg <= length_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_reg <= rd;
            st_reg <= st;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_read_value = rd_reg;
    assign m_status     = st_reg;
    assign m_count      = length_reg;

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        length_reg <= CNT_W'(DEPTH))
        else $error("list length beyond capacity");

    a_one_shift: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.up && cmd.down))
        else $error("cells told to shift both ways");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && st_reg == ST_FULL |-> length_reg == CNT_W'(DEPTH))
        else $error("full status with spare capacity");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid_reg)
        else $error("accepted request gave no result");

endmodule

### src/indexed_insert_delete_list.sv
// Indexed insert/delete list: a row of DEPTH word cells shifted in parallel.
// The result is registered and valid in the cycle after a request is accepted.
// Throughput: one request per cycle; s_ready drops only while a result stalls.
// Reset (aresetn, synchronous): empties the list and drops m_valid; cell
// contents are left as they are and never read before being written.
module indexed_insert_delete_list
    import iidl_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [1:0]               s_op,
    input  logic [IDX_W-1:0]         s_index,
    input  logic signed [DATA_W-1:0] s_value,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_read_value,
    output logic [1:0]               m_status,
    output logic [CNT_W-1:0]         m_count
);

    cell_cmd_t         cmd;
    logic [DATA_W-1:0] words [DEPTH];
    logic [DATA_W-1:0] rd_word;

    assign rd_word = words[s_index[SEL_W-1:0]];

    iidl_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_index      (s_index),
        .s_value      (s_value),
        .rd_word      (rd_word),
        .cmd          (cmd),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_value (m_read_value),
        .m_status     (m_status),
        .m_count      (m_count)
    );

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_W-1:0] left_word;
        logic [DATA_W-1:0] right_word;

        if (g == 0) begin : g_first
            assign left_word = '0;
        end else begin : g_left
            assign left_word = words[g-1];
        end

        if (g == DEPTH-1) begin : g_last
            assign right_word = '0;
        end else begin : g_right
            assign right_word = words[g+1];
        end

        iidl_cell u_cell (
            .aclk       (aclk),
            .cell_pos   (CNT_W'(g)),
            .cmd        (cmd),
            .left_word  (left_word),
            .right_word (right_word),
            .word       (words[g])
        );
    end

endmodule
